// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, masked while reset is high
`define MRK_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("check failed");

// concurrent check that also runs during reset
`define MRK_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("check failed");

`endif

// ----- sv/mrk_pkg.sv -----
// types, constants and the character table of the morse keyer
package mrk_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int COUNT_W = 20;
  localparam int DOT_W = 16;

  localparam logic [DOT_W-1:0] DOT_TICKS_RESET = 16'd60;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_ABORT = 2'd2;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_DOWN = 2'd1;
  localparam logic [1:0] EV_UP   = 2'd2;

  localparam logic REG_DOT_TICKS = 1'b0;

  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_DOWN = 4'b0010,
    PH_UP   = 4'b0100,
    PH_GAP  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       known;
    logic [2:0] len;
    logic [5:0] bits;
  } morse_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic       start_of_message;
  } item_t;

  typedef struct packed {
    logic       dropped;
    logic       busy_res;
    logic [1:0] event_res;
    logic       key;
  } result_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [8:0] wdata;
  } qctl_t;

  typedef struct packed {
    logic       nonempty;
    logic       multi;
    logic       full;
    logic [8:0] head_entry;
  } qstat_t;

  // element pattern, first element in bit 0, 1 is a dash
  function automatic morse_t morse_lookup(input logic [7:0] c);
    logic [7:0] lc;
    morse_t m;
    lc = (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;
    m = '0;
    m.known = 1'b1;
    case (lc)
      " ": begin m.len = 3'd0; m.bits = 6'b000000; end
      "a": begin m.len = 3'd2; m.bits = 6'b000010; end
      "b": begin m.len = 3'd4; m.bits = 6'b000001; end
      "c": begin m.len = 3'd4; m.bits = 6'b000101; end
      "d": begin m.len = 3'd3; m.bits = 6'b000001; end
      "e": begin m.len = 3'd1; m.bits = 6'b000000; end
      "f": begin m.len = 3'd4; m.bits = 6'b000100; end
      "g": begin m.len = 3'd3; m.bits = 6'b000011; end
      "h": begin m.len = 3'd4; m.bits = 6'b000000; end
      "i": begin m.len = 3'd2; m.bits = 6'b000000; end
      "j": begin m.len = 3'd4; m.bits = 6'b001110; end
      "k": begin m.len = 3'd3; m.bits = 6'b000101; end
      "l": begin m.len = 3'd4; m.bits = 6'b000010; end
      "m": begin m.len = 3'd2; m.bits = 6'b000011; end
      "n": begin m.len = 3'd2; m.bits = 6'b000001; end
      "o": begin m.len = 3'd3; m.bits = 6'b000111; end
      "p": begin m.len = 3'd4; m.bits = 6'b000110; end
      "q": begin m.len = 3'd4; m.bits = 6'b001011; end
      "r": begin m.len = 3'd3; m.bits = 6'b000010; end
      "s": begin m.len = 3'd3; m.bits = 6'b000000; end
      "t": begin m.len = 3'd1; m.bits = 6'b000001; end
      "u": begin m.len = 3'd3; m.bits = 6'b000100; end
      "v": begin m.len = 3'd4; m.bits = 6'b001000; end
      "w": begin m.len = 3'd3; m.bits = 6'b000110; end
      "x": begin m.len = 3'd4; m.bits = 6'b001001; end
      "y": begin m.len = 3'd4; m.bits = 6'b001101; end
      "z": begin m.len = 3'd4; m.bits = 6'b000011; end
      "1": begin m.len = 3'd5; m.bits = 6'b011110; end
      "2": begin m.len = 3'd5; m.bits = 6'b011100; end
      "3": begin m.len = 3'd5; m.bits = 6'b011000; end
      "4": begin m.len = 3'd5; m.bits = 6'b010000; end
      "5": begin m.len = 3'd5; m.bits = 6'b000000; end
      "6": begin m.len = 3'd5; m.bits = 6'b000001; end
      "7": begin m.len = 3'd5; m.bits = 6'b000011; end
      "8": begin m.len = 3'd5; m.bits = 6'b000111; end
      "9": begin m.len = 3'd5; m.bits = 6'b001111; end
      "0": begin m.len = 3'd5; m.bits = 6'b011111; end
      ",": begin m.len = 3'd5; m.bits = 6'b000100; end
      ".": begin m.len = 3'd6; m.bits = 6'b101010; end
      "/": begin m.len = 3'd5; m.bits = 6'b001001; end
      ";": begin m.len = 3'd5; m.bits = 6'b010101; end
      ":": begin m.len = 3'd6; m.bits = 6'b000111; end
      "+": begin m.len = 3'd5; m.bits = 6'b001010; end
      "-": begin m.len = 3'd6; m.bits = 6'b100001; end
      "=": begin m.len = 3'd5; m.bits = 6'b010001; end
      "?": begin m.len = 3'd6; m.bits = 6'b001100; end
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ----- sv/mrk_queue.sv -----
// character queue: memory with pointers, head entry kept in a read register
module mrk_queue #(
  parameter int DEPTH = mrk_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  mrk_pkg::qctl_t ctl,
  output mrk_pkg::qstat_t stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [8:0]       mem [DEPTH];
  logic [8:0]       head_entry;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] tail_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  always_comb begin
    head_next = head;
    tail_next = tail;
    count_next = count;
    if (ctl.clear) begin
      head_next = '0;
      tail_next = '0;
      count_next = '0;
    end else begin
      if (ctl.pop) begin
        head_next = (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
        count_next = count - 1'b1;
      end
      if (ctl.push) begin
        tail_next = (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
        count_next = count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      count <= count_next;
    end
  end

  // read the entry that will be at the head, forwarding a same-cycle write
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= ctl.wdata;
    end
    if (ctl.push && tail == head_next) begin
      head_entry <= ctl.wdata;
    end else begin
      head_entry <= mem[head_next];
    end
  end

  assign stat.nonempty = (count != '0);
  assign stat.multi = (count > CNT_W'(1));
  assign stat.full = (count == CNT_W'(DEPTH));
  assign stat.head_entry = head_entry;

endmodule

// ----- sv/mrk_engine.sv -----
// keying state machine: element timing, queue control and result fields
module mrk_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  mrk_pkg::item_t             item,
  input  logic [mrk_pkg::DOT_W-1:0]  dot_ticks,
  input  mrk_pkg::qstat_t            qstat,
  output mrk_pkg::qctl_t             qctl,
  output mrk_pkg::result_t           res
);

  mrk_pkg::phase_t                 phase;
  mrk_pkg::phase_t                 phase_next;
  logic [mrk_pkg::COUNT_W-1:0]     countdown;
  logic [mrk_pkg::COUNT_W-1:0]     countdown_next;
  logic [5:0]                      symbol_pattern;
  logic [5:0]                      symbol_pattern_next;
  logic [2:0]                      elements_left;
  logic [2:0]                      elements_left_next;
  logic                            key_level;
  logic                            key_level_next;

  logic [mrk_pkg::DOT_W-1:0]       dot;
  logic [mrk_pkg::COUNT_W-1:0]     u1;
  logic [mrk_pkg::COUNT_W-1:0]     u2;
  logic [mrk_pkg::COUNT_W-1:0]     u3;
  logic [mrk_pkg::COUNT_W-1:0]     u4;
  mrk_pkg::morse_t                 lk_in;
  mrk_pkg::morse_t                 lk_head;
  logic [5:0]                      pat;
  logic [2:0]                      el;
  logic                            go;
  logic                            head_som;
  logic                            head_space;
  logic [1:0]                      evt;
  logic                            drop;
  logic                            q_left;

  assign dot = (dot_ticks == '0) ? mrk_pkg::DOT_W'(1) : dot_ticks;
  assign u1 = mrk_pkg::COUNT_W'(dot);
  assign u2 = mrk_pkg::COUNT_W'({dot, 1'b0});
  assign u3 = u1 + u2;
  assign u4 = mrk_pkg::COUNT_W'({dot, 2'b00});

  assign lk_in = mrk_pkg::morse_lookup(item.char_code);
  assign lk_head = mrk_pkg::morse_lookup(qstat.head_entry[7:0]);
  assign head_som = qstat.head_entry[8];
  assign head_space = (qstat.head_entry[7:0] == mrk_pkg::CHAR_SPACE);

  always_comb begin
    phase_next = phase;
    countdown_next = countdown;
    symbol_pattern_next = symbol_pattern;
    elements_left_next = elements_left;
    key_level_next = key_level;
    qctl = '0;
    qctl.wdata = {item.start_of_message, item.char_code};
    evt = mrk_pkg::EV_NONE;
    drop = 1'b0;
    pat = symbol_pattern;
    el = elements_left;
    go = 1'b1;
    if (fire) begin
      case (item.kind)
        mrk_pkg::KIND_TICK: begin
          if (countdown > mrk_pkg::COUNT_W'(1)) begin
            countdown_next = countdown - 1'b1;
          end else if (phase == mrk_pkg::PH_DOWN) begin
            key_level_next = 1'b0;
            evt = mrk_pkg::EV_UP;
            countdown_next = u1;
            phase_next = mrk_pkg::PH_UP;
          end else begin
            // fetch the next character once the current one is done
            if (el == 3'd0 && qstat.nonempty) begin
              qctl.pop = 1'b1;
              pat = lk_head.bits;
              el = lk_head.len;
              if (!head_som || head_space) begin
                countdown_next = (!head_som && head_space) ? u4 : u2;
                phase_next = mrk_pkg::PH_GAP;
                go = 1'b0;
              end
            end
            symbol_pattern_next = pat;
            elements_left_next = el;
            if (go) begin
              if (el != 3'd0) begin
                symbol_pattern_next = {1'b0, pat[5:1]};
                elements_left_next = el - 1'b1;
                key_level_next = 1'b1;
                evt = mrk_pkg::EV_DOWN;
                countdown_next = pat[0] ? u3 : u1;
                phase_next = mrk_pkg::PH_DOWN;
              end else begin
                phase_next = mrk_pkg::PH_IDLE;
                countdown_next = '0;
              end
            end
          end
        end
        mrk_pkg::KIND_CHAR: begin
          if (!lk_in.known || qstat.full) begin
            drop = 1'b1;
          end else begin
            qctl.push = 1'b1;
          end
        end
        mrk_pkg::KIND_ABORT: begin
          evt = key_level ? mrk_pkg::EV_UP : mrk_pkg::EV_NONE;
          key_level_next = 1'b0;
          qctl.clear = 1'b1;
          symbol_pattern_next = '0;
          elements_left_next = '0;
          phase_next = mrk_pkg::PH_IDLE;
          countdown_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // queue occupancy after this request; push and pop never coincide
  always_comb begin
    if (qctl.clear) begin
      q_left = 1'b0;
    end else if (qctl.push) begin
      q_left = 1'b1;
    end else if (qctl.pop) begin
      q_left = qstat.multi;
    end else begin
      q_left = qstat.nonempty;
    end
  end

  assign res.key = key_level_next;
  assign res.event_res = evt;
  assign res.busy_res = (phase_next != mrk_pkg::PH_IDLE) || q_left;
  assign res.dropped = drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= mrk_pkg::PH_IDLE;
      countdown <= '0;
      symbol_pattern <= '0;
      elements_left <= '0;
      key_level <= 1'b0;
    end else begin
      phase <= phase_next;
      countdown <= countdown_next;
      symbol_pattern <= symbol_pattern_next;
      elements_left <= elements_left_next;
      key_level <= key_level_next;
    end
  end

endmodule

// ----- sv/morse_keyer_core.sv -----
// morse keyer top level: stream ports, register port, request and result stages
// a request is held in the input register, then its result in the output register
// throughput: one request per cycle while the receiver takes results; each request is one lookup and one counter step
// an empty input register takes a request while a result waits in the output register
// reset (rst, synchronous) clears control state and sets dot_ticks to 60
// the queue memory is not cleared; entries are only read after being written
module morse_keyer_core #(
  parameter int QUEUE_DEPTH = mrk_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // char_code[7:0], start_of_message[8], zero fill
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // key[0], event_res[2:1], busy_res[3], dropped[4], zero fill
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                       in_valid;
  mrk_pkg::item_t             in_item;
  logic                       stage_ready;
  logic                       fire;
  logic [mrk_pkg::DOT_W-1:0]  dot_ticks;
  mrk_pkg::qctl_t             qctl;
  mrk_pkg::qstat_t            qstat;
  mrk_pkg::result_t           res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mrk_pkg::REG_DOT_TICKS) ? {16'b0, dot_ticks} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_ticks <= mrk_pkg::DOT_TICKS_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == mrk_pkg::REG_DOT_TICKS) begin
      dot_ticks <= pwdata[15:0];
    end
  end

  assign stage_ready = !m_tvalid || m_tready;
  assign fire = in_valid && stage_ready;
  assign s_tready = !in_valid || stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.kind <= s_tuser;
      in_item.char_code <= s_tdata[7:0];
      in_item.start_of_message <= s_tdata[8];
    end
  end

  mrk_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .ctl  (qctl),
    .stat (qstat)
  );

  mrk_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (in_item),
    .dot_ticks (dot_ticks),
    .qstat     (qstat),
    .qctl      (qctl),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (stage_ready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {3'b000, res};
    end
  end

endmodule

// ----- sv/mrk_checker.sv -----
// port-level checks for the morse keyer, bound to the top level
`include "assert_macros.svh"

module mrk_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic [7:0] m_tdata
);

  // key-down event must leave the key down, key-up event must leave it up
  `MRK_ASSERT(a_down_key, clk, rst, m_tvalid && m_tdata[2:1] == mrk_pkg::EV_DOWN |-> m_tdata[0])
  `MRK_ASSERT(a_up_key, clk, rst, m_tvalid && m_tdata[2:1] == mrk_pkg::EV_UP |-> !m_tdata[0])
  // a rejected character never moves the key
  `MRK_ASSERT(a_drop_quiet, clk, rst, m_tvalid && m_tdata[4] |-> m_tdata[2:1] == mrk_pkg::EV_NONE)
  // key held down means an element is being sent
  `MRK_ASSERT(a_key_busy, clk, rst, m_tvalid && m_tdata[0] |-> m_tdata[3])
  `MRK_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_tvalid)

endmodule

bind morse_keyer_core mrk_checker u_mrk_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tdata  (m_tdata)
);

// ----- sim/tb_top.sv -----
// self-checking testbench for the morse keyer against a keying predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mrk_pkg::*;

  localparam logic [1:0] KIND_IGNORED = 2'd3;
  localparam logic [2:0] DOT_ADDR = 3'(4 * REG_DOT_TICKS);
  localparam string SENDABLE = " abcdefghijklmnopqrstuvwxyz1234567890,.?;:/+-=";

  // keying predictor and store of expected results
  class keyer_scoreboard;
    logic [15:0] dot_len;
    logic [8:0]  char_fifo [QUEUE_DEPTH];
    int          head;
    int          tail;
    int          count;
    logic [5:0]  pattern;
    int          left;
    phase_t      ph;
    logic [19:0] countdown;
    logic        key_down;
    string       code_of [bit [7:0]];
    result_t     expected_keying [$];
    int          errors;

    function new();
      string codes [46];
      codes = '{"", ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...",
                "-", "..-", "...-", ".--", "-..-", "-.--", "--..", ".----", "..---",
                "...--", "....-", ".....", "-....", "--...", "---..", "----.", "-----",
                "..-..", ".-.-.-", "..--..", "-.-.-", "---...", "-..-.", ".-.-.",
                "-....-", "-...-"};
      for (int i = 0; i < 46; i++) code_of[SENDABLE[i]] = codes[i];
      dot_len = DOT_TICKS_RESET;
      head = 0;
      tail = 0;
      count = 0;
      pattern = '0;
      left = 0;
      ph = PH_IDLE;
      countdown = '0;
      key_down = 1'b0;
      errors = 0;
    endfunction

    function bit decode(input logic [7:0] c, output int len, output logic [5:0] bits);
      string s;
      logic [7:0] lc;
      len = 0;
      bits = '0;
      lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
      if (!code_of.exists(lc)) return 1'b0;
      s = code_of[lc];
      len = s.len();
      for (int i = 0; i < len; i++) if (s[i] == "-") bits[i] = 1'b1;
      return 1'b1;
    endfunction

    function logic [19:0] units(input int n);
      int d;
      d = (dot_len == 0) ? 1 : int'(dot_len);
      return 20'(n * d);
    endfunction

    function logic [1:0] tick();
      logic [8:0] e;
      int len;
      int gap;
      logic [5:0] bits;
      logic dash;
      if (countdown > 0) begin
        countdown = countdown - 1;
        if (countdown > 0) return EV_NONE;
      end
      if (ph == PH_DOWN) begin
        key_down = 1'b0;
        countdown = units(1);
        ph = PH_UP;
        return EV_UP;
      end
      if (left == 0 && count > 0) begin
        e = char_fifo[head];
        head = (head + 1) % QUEUE_DEPTH;
        count--;
        void'(decode(e[7:0], len, bits));
        pattern = bits;
        left = len;
        gap = e[8] ? 0 : 2;
        if (e[7:0] == CHAR_SPACE) gap += 2;
        if (gap > 0) begin
          countdown = units(gap);
          ph = PH_GAP;
          return EV_NONE;
        end
      end
      if (left > 0) begin
        dash = pattern[0];
        pattern = pattern >> 1;
        left--;
        key_down = 1'b1;
        countdown = units(dash ? 3 : 1);
        ph = PH_DOWN;
        return EV_DOWN;
      end
      ph = PH_IDLE;
      countdown = '0;
      return EV_NONE;
    endfunction

    function void note_request(input item_t it);
      result_t r;
      logic [1:0] ev;
      logic drop;
      int len;
      logic [5:0] bits;
      ev = EV_NONE;
      drop = 1'b0;
      case (it.kind)
        KIND_TICK: ev = tick();
        KIND_CHAR: begin
          if (!decode(it.char_code, len, bits) || count >= QUEUE_DEPTH) begin
            drop = 1'b1;
          end else begin
            char_fifo[tail] = {it.start_of_message, it.char_code};
            tail = (tail + 1) % QUEUE_DEPTH;
            count++;
          end
        end
        KIND_ABORT: begin
          if (key_down) ev = EV_UP;
          key_down = 1'b0;
          head = 0;
          tail = 0;
          count = 0;
          pattern = '0;
          left = 0;
          ph = PH_IDLE;
          countdown = '0;
        end
        default: ;
      endcase
      r.key = key_down;
      r.event_res = ev;
      r.busy_res = (ph != PH_IDLE) || (count > 0);
      r.dropped = drop;
      expected_keying.insert(expected_keying.size(), r);
    endfunction

    function void flag(input string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (expected_keying.size() == 0) begin
        flag($sformatf("result with nothing expected: key=%0d event=%0d busy=%0d dropped=%0d",
                       got.key, got.event_res, got.busy_res, got.dropped));
        return;
      end
      want = expected_keying.pop_front();
      if (got.key !== want.key || got.event_res !== want.event_res ||
          got.busy_res !== want.busy_res || got.dropped !== want.dropped)
        flag($sformatf("expected key=%0d event=%0d busy=%0d dropped=%0d, got %0d %0d %0d %0d",
                       want.key, want.event_res, want.busy_res, want.dropped,
                       got.key, got.event_res, got.busy_res, got.dropped));
    endfunction

    function int pending();
      return expected_keying.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // char_code[7:0], start_of_message[8], zero fill
  logic [1:0]  s_tuser = '0;   // kind[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // key[0], event_res[2:1], busy_res[3], dropped[4], zero fill
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  keyer_scoreboard sb;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int live_items = 0;
  int stall_left = 0;
  logic [15:0] stall_mask = 16'hFFFF;

  morse_keyer_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: rotating stall mask, sometimes never stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left = 48 + $urandom_range(0, 80);
      stall_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end
    stall_left--;
    m_tready <= stall_mask[stall_left % 16];
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(result_t'(m_tdata[4:0]));
  end

  task automatic send_item(input logic [1:0] kind, input logic [7:0] ch, input logic som);
    if (gaps_on && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {7'd0, som, ch};
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_request('{kind: kind, char_code: ch, start_of_message: som});
    if (kind != KIND_IGNORED) live_items++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == DOT_ADDR) sb.dot_len = data[15:0];
  endtask

  task automatic reg_read_check(input logic [2:0] addr, input logic [31:0] want);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== want) sb.flag($sformatf("register read expected %0h, got %0h", want, got));
  endtask

  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    c = SENDABLE[$urandom_range(0, SENDABLE.len() - 1)];
    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
    return c;
  endfunction

  // more characters than the queue holds, no ticks in between
  task automatic flood();
    repeat (QUEUE_DEPTH + 2) send_item(KIND_CHAR, pick_char(), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_phase(input int budget);
    int start;
    int pick;
    int n;
    int eff;
    int t;
    start = live_items;
    eff = (sb.dot_len == 0) ? 1 : int'(sb.dot_len);
    while (live_items - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // a word, then roughly enough ticks to key it out
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          send_item(KIND_CHAR, pick_char(),
                    (i == 0) ? 1'($urandom_range(0, 1)) : 1'($urandom_range(0, 9) == 0));
        t = n * $urandom_range(2, 28) * eff;
        if (t > 300) t = $urandom_range(40, 300);
        // keep the phase close to its request budget
        if (t > budget - (live_items - start)) t = budget - (live_items - start);
        if (t < 0) t = 0;
        repeat (t) send_item(KIND_TICK, 8'($urandom), 1'($urandom));
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 40)) send_item(KIND_TICK, 8'($urandom), 1'($urandom));
      end else if (pick < 82) begin
        send_item(KIND_ABORT, 8'($urandom), 1'($urandom));
      end else if (pick < 94) begin
        send_item(2'($urandom), 8'($urandom), 1'($urandom));
      end else if (pick < 98) begin
        // word cut off by an abort
        send_item(KIND_CHAR, pick_char(), 1'($urandom_range(0, 1)));
        send_item(KIND_CHAR, pick_char(), 1'b0);
        repeat ($urandom_range(1, 8)) send_item(KIND_TICK, 8'h00, 1'b0);
        send_item(KIND_ABORT, 8'h00, 1'b0);
      end else begin
        flood();
      end
    end
  endtask

  initial begin
    item_t directed [$];
    int dot_plan [6];
    int budget_plan [6];
    logic [31:0] wr;
    dot_plan = '{1, 2, 65535, 3, 0, 5};
    budget_plan = '{180, 140, 40, 130, 100, 70};
    directed = '{
      '{KIND_ABORT, 8'h00, 1'b0},
      '{KIND_CHAR, "E", 1'b1},          // upper case, no leading gap
      '{KIND_TICK, 8'h00, 1'b0},
      '{KIND_TICK, 8'h00, 1'b0},
      '{KIND_TICK, 8'h00, 1'b0},
      '{KIND_CHAR, 8'hFF, 1'b1},        // not in the table
      '{KIND_CHAR, 8'h00, 1'b0},
      '{KIND_CHAR, "?", 1'b0},
      '{KIND_CHAR, " ", 1'b0},
      '{KIND_CHAR, "0", 1'b1},
      '{KIND_IGNORED, 8'hAA, 1'b1},
      '{KIND_TICK, 8'h00, 1'b0},
      '{KIND_TICK, 8'h00, 1'b0},
      '{KIND_TICK, 8'h00, 1'b0},
      '{KIND_TICK, 8'h00, 1'b0},
      '{KIND_TICK, 8'h00, 1'b0},
      '{KIND_TICK, 8'h00, 1'b0},
      '{KIND_ABORT, 8'h00, 1'b0},       // key up, queue not empty
      '{KIND_CHAR, "-", 1'b0},
      '{KIND_CHAR, "z", 1'b1},
      '{KIND_TICK, 8'h00, 1'b0},
      '{KIND_TICK, 8'h00, 1'b0},
      '{KIND_TICK, 8'h00, 1'b0},
      '{KIND_ABORT, 8'h00, 1'b0},       // key down
      '{KIND_IGNORED, 8'hFF, 1'b0},
      '{KIND_ABORT, 8'h00, 1'b1}        // already idle
    };
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    reg_read_check(DOT_ADDR, {16'd0, DOT_TICKS_RESET});
    run_phase(100);
    drain();

    // zero dot length behaves as one
    reg_write(DOT_ADDR, 32'd0);
    reg_read_check(DOT_ADDR, 32'd0);
    foreach (directed[i])
      send_item(directed[i].kind, directed[i].char_code, directed[i].start_of_message);
    drain();

    foreach (dot_plan[p]) begin
      wr = {16'($urandom), 16'(dot_plan[p])};
      reg_write(DOT_ADDR, wr);
      reg_read_check(DOT_ADDR, {16'd0, wr[15:0]});
      gaps_on = ($urandom_range(0, 3) != 0);
      if (dot_plan[p] == 1) flood();
      run_phase(budget_plan[p]);
      // long countdowns would stall the following settings
      if (dot_plan[p] == 65535) send_item(KIND_ABORT, 8'h00, 1'b0);
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
